// ===== rtl/core/stkvm_pkg.sv =====
`default_nettype none
package stkvm_pkg;

  // STACK_DEPTH must be a power of two: the stack slot is the low pointer bits.
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned ADDR_BITS   = 16;
  localparam int unsigned Q_DEPTH     = 2;

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
  localparam int unsigned REG_W = $clog2(REG_COUNT);
  localparam int unsigned Q_AW  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW  = $clog2(Q_DEPTH + 1);

  localparam logic [REG_W-1:0] IP_IDX = REG_W'(REG_COUNT - 2);
  localparam logic [REG_W-1:0] SP_IDX = REG_W'(REG_COUNT - 1);
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [3:0] {
    OP_PSH = 4'd0,
    OP_POP = 4'd1,
    OP_LOG = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_MUL = 4'd5,
    OP_DIV = 4'd6,
    OP_MOV = 4'd7,
    OP_SET = 4'd8,
    OP_IF  = 4'd9,
    OP_IFN = 4'd10,
    OP_JMP = 4'd11,
    OP_STR = 4'd12,
    OP_RTS = 4'd13,
    OP_EXT = 4'd14,
    OP_NOP = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_UNF  = 2'd2,
    ERR_DIV0 = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0,
    CLS_READ   = 2'd1,
    CLS_ALU    = 2'd2
  } cls_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_RDA  = 3'd1,
    S_RDB  = 3'd2,
    S_CALC = 3'd3,
    S_DIV  = 3'd4,
    S_WB   = 3'd5,
    S_TOP  = 3'd6,
    S_OUT  = 3'd7
  } state_e;

  typedef struct packed {
    logic [3:0]         mode;
    logic [2:0]         reg_a;
    logic [2:0]         reg_b;
    logic signed [31:0] imm;
    logic [15:0]        target;
  } in_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic               halted;
    logic               log_valid;
    logic signed [31:0] log_value;
    logic [1:0]         error;
    logic signed [31:0] top_value;
  } out_t;

  typedef struct packed {
    op_e              op;
    cls_e             cls;
    logic [REG_W-1:0] ra;
    logic [REG_W-1:0] rb;
    logic [31:0]      imm;
    logic [15:0]      target;
  } dec_t;

  // Reduce a 3-bit register operand modulo REG_COUNT (REG_COUNT >= 4).
  function automatic logic [REG_W-1:0] reg_idx(input logic [2:0] x);
    logic [7:0] v;
    v = {5'd0, x};
    if (v >= 8'(REG_COUNT)) begin
      v = v - 8'(REG_COUNT);
    end
    return v[REG_W-1:0];
  endfunction

  function automatic logic [SP_W-1:0] slot(input logic [31:0] sp);
    return sp[SP_W-1:0];
  endfunction

  function automatic err_e range_code(input logic [31:0] sp);
    if (sp[31]) begin
      return ERR_UNF;
    end
    if (sp >= 32'(STACK_DEPTH)) begin
      return ERR_OVF;
    end
    return ERR_NONE;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stkvm_ram.sv =====
`default_nettype none
module stkvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/stkvm_front.sv =====
`default_nettype none
module stkvm_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire stkvm_pkg::in_t   in_data_i,
  output logic                  q_valid_o,
  output stkvm_pkg::dec_t       q_item_o,
  input  wire logic             q_pop_i
);

  stkvm_pkg::dec_t                 fifo_q [stkvm_pkg::Q_DEPTH];
  logic [stkvm_pkg::Q_AW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [stkvm_pkg::Q_CW-1:0]      cnt_q, cnt_d;
  stkvm_pkg::dec_t                 dec;
  logic                            push, pop;

  // Classify by how much stack reading the instruction needs.
  always_comb begin
    dec.op     = stkvm_pkg::op_e'(in_data_i.mode);
    dec.ra     = stkvm_pkg::reg_idx(in_data_i.reg_a);
    dec.rb     = stkvm_pkg::reg_idx(in_data_i.reg_b);
    dec.imm    = in_data_i.imm;
    dec.target = in_data_i.target;
    case (dec.op)
      stkvm_pkg::OP_ADD, stkvm_pkg::OP_SUB,
      stkvm_pkg::OP_MUL, stkvm_pkg::OP_DIV: dec.cls = stkvm_pkg::CLS_ALU;
      stkvm_pkg::OP_STR:                    dec.cls = stkvm_pkg::CLS_READ;
      default:                              dec.cls = stkvm_pkg::CLS_DIRECT;
    endcase
  end

  assign in_stall_o = (cnt_q == stkvm_pkg::Q_CW'(stkvm_pkg::Q_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == stkvm_pkg::Q_AW'(stkvm_pkg::Q_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == stkvm_pkg::Q_AW'(stkvm_pkg::Q_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/stkvm_back.sv =====
`default_nettype none
module stkvm_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire stkvm_pkg::dec_t  q_item_i,
  output logic                  q_pop_o,
  input  wire logic [16:0]      prog_len_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output stkvm_pkg::out_t       out_data_o
);

  stkvm_pkg::state_e state_q, state_d;
  logic [31:0]       rf_q [stkvm_pkg::REG_COUNT];
  logic [31:0]       rf_d [stkvm_pkg::REG_COUNT];
  logic              run_q, run_d;
  stkvm_pkg::dec_t   ins_q, ins_d;
  logic [31:0]       a_q, a_d, b_q, b_d, c_q, c_d;
  stkvm_pkg::err_e   err_q, err_d;
  logic              logv_q, logv_d;
  logic [31:0]       logval_q, logval_d;
  logic [31:0]       rem_q, rem_d, quo_q, quo_d, dabs_q, dabs_d;
  logic              neg_q, neg_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  stkvm_pkg::out_t   out_q, out_d;

  logic                       mem_we;
  logic [stkvm_pkg::SP_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]                mem_wdata, mem_rdata;

  logic [31:0] sp, ip, len, v, spn, nabs, qn, prod;
  logic [32:0] trial;
  logic        jumped, halted_now, out_free;

  stkvm_ram #(.WIDTH(32), .DEPTH(stkvm_pkg::STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign sp         = rf_q[stkvm_pkg::SP_IDX];
  assign ip         = rf_q[stkvm_pkg::IP_IDX];
  assign halted_now = !run_q || (ip >= 32'(prog_len_i));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign q_pop_o    = (state_q == stkvm_pkg::S_IDLE) && q_valid_i;
  assign mem_raddr  = (state_q == stkvm_pkg::S_RDA) ? stkvm_pkg::slot(sp - 32'd1)
                    : stkvm_pkg::slot(sp);
  assign prod       = 32'(a_q * b_q);
  assign trial      = {rem_q, quo_q[31]};

  always_comb begin
    state_d     = state_q;
    rf_d        = rf_q;
    run_d       = run_q;
    ins_d       = ins_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    err_d       = err_q;
    logv_d      = logv_q;
    logval_d    = logval_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dabs_d      = dabs_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = stkvm_pkg::slot(sp);
    mem_wdata   = c_q;
    len         = 32'd1;
    jumped      = 1'b0;
    v           = '0;
    spn         = sp + 32'd1;
    nabs        = '0;
    qn          = '0;

    case (state_q)
      stkvm_pkg::S_IDLE: begin
        if (q_valid_i) begin
          ins_d    = q_item_i;
          err_d    = stkvm_pkg::ERR_NONE;
          logv_d   = 1'b0;
          logval_d = '0;
          if (halted_now) begin
            state_d = stkvm_pkg::S_TOP;
          end else if (q_item_i.cls != stkvm_pkg::CLS_DIRECT) begin
            state_d = stkvm_pkg::S_RDA;
          end else begin
            state_d = stkvm_pkg::S_TOP;
            case (q_item_i.op)
              stkvm_pkg::OP_PSH, stkvm_pkg::OP_RTS: begin
                v = (q_item_i.op == stkvm_pkg::OP_PSH) ? q_item_i.imm
                  : rf_q[q_item_i.ra];
                err_d     = stkvm_pkg::range_code(spn);
                mem_we    = 1'b1;
                mem_waddr = stkvm_pkg::slot(spn);
                mem_wdata = v;
                rf_d[stkvm_pkg::SP_IDX] = spn;
                len = 32'd2;
              end
              stkvm_pkg::OP_POP: begin
                err_d = stkvm_pkg::range_code(sp);
                rf_d[stkvm_pkg::SP_IDX] = sp - 32'd1;
              end
              stkvm_pkg::OP_LOG: begin
                logv_d   = 1'b1;
                logval_d = rf_q[q_item_i.ra];
                len      = 32'd2;
              end
              stkvm_pkg::OP_MOV: begin
                rf_d[q_item_i.rb] = rf_q[q_item_i.ra];
                len = 32'd3;
              end
              stkvm_pkg::OP_SET: begin
                rf_d[q_item_i.ra] = q_item_i.imm;
                len = 32'd3;
              end
              stkvm_pkg::OP_IF, stkvm_pkg::OP_IFN: begin
                jumped = ((rf_q[q_item_i.ra] == q_item_i.imm)
                          == (q_item_i.op == stkvm_pkg::OP_IF));
                len = 32'd4;
              end
              stkvm_pkg::OP_JMP: jumped = 1'b1;
              stkvm_pkg::OP_EXT: run_d = 1'b0;
              default: len = 32'd1;
            endcase
            // Pointer register writes land before the length is added.
            rf_d[stkvm_pkg::IP_IDX] = jumped ? {16'd0, q_item_i.target}
                                    : rf_d[stkvm_pkg::IP_IDX] + len;
          end
        end
      end

      stkvm_pkg::S_RDA: begin
        a_d   = mem_rdata;
        err_d = stkvm_pkg::range_code(sp);
        if (ins_q.cls == stkvm_pkg::CLS_READ) begin
          rf_d[ins_q.ra] = mem_rdata;
          rf_d[stkvm_pkg::IP_IDX] = rf_d[stkvm_pkg::IP_IDX] + 32'd2;
          state_d = stkvm_pkg::S_TOP;
        end else begin
          state_d = stkvm_pkg::S_RDB;
        end
      end

      stkvm_pkg::S_RDB: begin
        b_d = mem_rdata;
        if (err_q == stkvm_pkg::ERR_NONE) begin
          err_d = stkvm_pkg::range_code(sp - 32'd1);
        end
        state_d = stkvm_pkg::S_CALC;
      end

      stkvm_pkg::S_CALC: begin
        state_d = stkvm_pkg::S_WB;
        case (ins_q.op)
          stkvm_pkg::OP_ADD: c_d = a_q + b_q;
          stkvm_pkg::OP_SUB: c_d = b_q - a_q;
          stkvm_pkg::OP_MUL: c_d = prod;
          stkvm_pkg::OP_DIV: begin
            if (a_q == '0) begin
              c_d = '0;
              if (err_q == stkvm_pkg::ERR_NONE) begin
                err_d = stkvm_pkg::ERR_DIV0;
              end
            end else begin
              nabs    = b_q[31] ? (32'd0 - b_q) : b_q;
              dabs_d  = a_q[31] ? (32'd0 - a_q) : a_q;
              rem_d   = '0;
              quo_d   = nabs;
              neg_d   = a_q[31] ^ b_q[31];
              cnt_d   = 5'd31;
              state_d = stkvm_pkg::S_DIV;
            end
          end
          default: c_d = c_q;
        endcase
      end

      stkvm_pkg::S_DIV: begin
        // One restoring step per cycle.
        if (trial >= {1'b0, dabs_q}) begin
          rem_d = 32'(trial - {1'b0, dabs_q});
          qn    = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          qn    = {quo_q[30:0], 1'b0};
        end
        quo_d = qn;
        if (cnt_q == '0) begin
          c_d     = neg_q ? (32'd0 - qn) : qn;
          state_d = stkvm_pkg::S_WB;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end

      stkvm_pkg::S_WB: begin
        rf_d[0]   = a_q;
        rf_d[1]   = b_q;
        rf_d[2]   = c_q;
        mem_we    = 1'b1;
        mem_waddr = stkvm_pkg::slot(sp - 32'd1);
        mem_wdata = c_q;
        rf_d[stkvm_pkg::SP_IDX] = sp - 32'd1;
        rf_d[stkvm_pkg::IP_IDX] = ip + 32'd1;
        state_d = stkvm_pkg::S_TOP;
      end

      stkvm_pkg::S_TOP: state_d = stkvm_pkg::S_OUT;

      stkvm_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.next_ip     = 16'(ip & stkvm_pkg::ADDR_MASK);
          out_d.halted      = halted_now;
          out_d.log_valid   = logv_q;
          out_d.log_value   = logval_q;
          out_d.error       = err_q;
          out_d.top_value   = (stkvm_pkg::range_code(sp) == stkvm_pkg::ERR_NONE)
                            ? mem_rdata : '0;
          state_d           = stkvm_pkg::S_IDLE;
        end
      end

      default: state_d = stkvm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stkvm_pkg::S_IDLE;
      run_q       <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(stkvm_pkg::REG_COUNT); i++) begin
        rf_q[i] <= (i == int'(stkvm_pkg::REG_COUNT) - 1) ? 32'hFFFF_FFFF : 32'd0;
      end
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      rf_q        <= rf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q    <= ins_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    err_q    <= err_d;
    logv_q   <= logv_d;
    logval_q <= logval_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dabs_q   <= dabs_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/stack_vm_execute_unit.sv =====
// Sequence: simple instructions pass idle, top read and output; str adds one stack
//   read; add/sub/mul read two stack entries, calculate and write back; div also
//   runs 32 divider steps. One instruction runs at a time; the queue holds two more.
// Reset (async, active low): stack pointer all ones, other registers zero,
//   running, program length zero, queue and output empty; stack undefined.
`default_nettype none
module stack_vm_execute_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire stkvm_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output stkvm_pkg::out_t       out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [16:0]      cfg_wdata_i
);

  // Program length: instructions execute only while the pointer is below it.
  logic [16:0] prog_len_q;

  // Queue between decode and execute.
  logic            q_valid;
  logic            q_pop;
  stkvm_pkg::dec_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (cfg_we_i) begin
      prog_len_q <= cfg_wdata_i;
    end
  end

  // Front: accept transactions, reduce register indexes, classify the opcode.
  stkvm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // Back: hold the machine state, sequence stack reads, multiply and divide,
  // and drive the result register.
  stkvm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .prog_len_i  (prog_len_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Execute never pulls from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty instruction queue");

  // A log instruction cannot raise an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.log_valid |-> out_data_o.error == stkvm_pkg::ERR_NONE)
    else $error("log result carries an error");

  // Logged value is zero unless a log ran.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.log_valid |-> out_data_o.log_value == '0)
    else $error("log value without log");

endmodule
`default_nettype wire

// ===== tb/sv/stack_vm_execute_unit_test.sv =====
`default_nettype none
module stack_vm_execute_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stkvm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  stack_vm_execute_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  // Shadow state of the machine, advanced once per accepted transaction.
  logic [31:0] vm_regs [REG_COUNT];
  logic [31:0] vm_stack [STACK_DEPTH];
  logic vm_running;
  logic [16:0] vm_prog_len;
  out_t expected_q [$];

  int mismatch_count = 0;
  int result_count = 0;
  int sent_count = 0;
  int log_count = 0;
  int error_count = 0;
  int stall_left = 0;
  bit idle_enable = 1'b1;
  bit hold_outputs = 1'b0;

  function automatic logic [31:0] quotient(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] n, d, q;
    n = num[31] ? -num : num;
    d = den[31] ? -den : den;
    q = n / d;
    return (num[31] ^ den[31]) ? -q : q;
  endfunction

  function automatic logic [1:0] sp_status(input logic [31:0] sp);
    if (sp[31]) return ERR_UNF;
    if (sp >= 32'(STACK_DEPTH)) return ERR_OVF;
    return ERR_NONE;
  endfunction

  function automatic bit vm_halted();
    return !vm_running || ({15'd0, vm_prog_len} <= vm_regs[REG_COUNT-2]);
  endfunction

  // Execute one instruction on the shadow state and return the expected result.
  function automatic out_t execute(input in_t ins);
    out_t r;
    logic [1:0] err;
    logic [31:0] sp, a, b, c, v, len, top;
    int ra, rb;
    bit jumped;
    err = ERR_NONE;
    r = '0;
    ra = ins.reg_a % REG_COUNT;
    rb = ins.reg_b % REG_COUNT;
    if (!vm_halted()) begin
      len = 1;
      jumped = 0;
      sp = vm_regs[REG_COUNT-1];
      case (op_e'(ins.mode))
        OP_PSH, OP_RTS: begin
          v = (ins.mode == OP_PSH) ? ins.imm : vm_regs[ra];
          sp = sp + 1;
          if (err == ERR_NONE) err = sp_status(sp);
          vm_stack[sp % STACK_DEPTH] = v;
          vm_regs[REG_COUNT-1] = sp;
          len = 2;
        end
        OP_POP: begin
          if (err == ERR_NONE) err = sp_status(sp);
          vm_regs[REG_COUNT-1] = sp - 1;
        end
        OP_LOG: begin
          r.log_valid = 1'b1;
          r.log_value = vm_regs[ra];
          len = 2;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (err == ERR_NONE) err = sp_status(sp);
          a = vm_stack[sp % STACK_DEPTH];
          sp = sp - 1;
          if (err == ERR_NONE) err = sp_status(sp);
          b = vm_stack[sp % STACK_DEPTH];
          if (ins.mode == OP_ADD) c = a + b;
          else if (ins.mode == OP_SUB) c = b - a;
          else if (ins.mode == OP_MUL) c = a * b;
          else if (a == 0) begin
            c = 0;
            if (err == ERR_NONE) err = ERR_DIV0;
          end else c = quotient(b, a);
          vm_regs[0] = a;
          vm_regs[1] = b;
          vm_regs[2] = c;
          vm_stack[sp % STACK_DEPTH] = c;
          vm_regs[REG_COUNT-1] = sp;
        end
        OP_MOV: begin vm_regs[rb] = vm_regs[ra]; len = 3; end
        OP_SET: begin vm_regs[ra] = ins.imm; len = 3; end
        OP_IF, OP_IFN: begin
          jumped = ((vm_regs[ra] == ins.imm) == (ins.mode == OP_IF));
          len = 4;
        end
        OP_JMP: jumped = 1;
        OP_STR: begin
          if (err == ERR_NONE) err = sp_status(sp);
          vm_regs[ra] = vm_stack[sp % STACK_DEPTH];
          len = 2;
        end
        OP_EXT: vm_running = 1'b0;
        default: ;
      endcase
      if (jumped) vm_regs[REG_COUNT-2] = {16'd0, ins.target};
      else vm_regs[REG_COUNT-2] = vm_regs[REG_COUNT-2] + len;
    end
    sp = vm_regs[REG_COUNT-1];
    top = (sp_status(sp) == ERR_NONE) ? vm_stack[sp % STACK_DEPTH] : 32'd0;
    r.next_ip = vm_regs[REG_COUNT-2][15:0];
    r.halted = vm_halted();
    r.error = err;
    r.top_value = top;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %h want %h", result_count, what, got, want);
  endtask

  // Push one transaction, with an occasional idle burst ahead of it.
  task automatic send(input in_t ins);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ins;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(execute(ins));
    sent_count++;
  endtask

  function automatic in_t make(input op_e op, input logic [2:0] ra, input logic [2:0] rb,
                               input logic [31:0] imm, input logic [15:0] tgt);
    in_t i;
    i.mode = op; i.reg_a = ra; i.reg_b = rb; i.imm = imm; i.target = tgt;
    return i;
  endfunction

  // Drop valid and wait until every expectation has been consumed.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_length(input logic [16:0] len);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    vm_prog_len = len;
  endtask

  // Bring a halted machine back to address zero under a new program length.
  task automatic restart(input logic [16:0] len);
    drain();
    write_length(17'h1_FFFF);
    send(make(OP_JMP, 3'd0, 3'd0, 32'd0, 16'd0));
    drain();
    write_length(len);
  endtask

  // Compare each completed transaction with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.next_ip !== want.next_ip)
          report_mismatch("next_ip", out_data.next_ip, want.next_ip);
        if (out_data.halted !== want.halted)
          report_mismatch("halted", out_data.halted, want.halted);
        if (out_data.log_valid !== want.log_valid)
          report_mismatch("log_valid", out_data.log_valid, want.log_valid);
        if (out_data.log_value !== want.log_value)
          report_mismatch("log_value", out_data.log_value, want.log_value);
        if (out_data.error !== want.error)
          report_mismatch("error", out_data.error, want.error);
        if (out_data.top_value !== want.top_value)
          report_mismatch("top_value", out_data.top_value, want.top_value);
        if (want.log_valid) log_count++;
        if (want.error != ERR_NONE) error_count++;
      end
    end
  end

  // Stall the result side in random bursts; hold it off on request.
  always @(posedge clk) begin
    if (hold_outputs) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Halted behavior: length zero after reset ignores everything.
  task automatic test_halted_after_reset();
    send(make(OP_PSH, 3'd0, 3'd0, 32'h1234_5678, 16'd0));
    send(make(OP_JMP, 3'd0, 3'd0, 32'd0, 16'd5));
    drain();
  endtask

  // Directed: every opcode but exit, field extremes, stack errors, division corners.
  task automatic test_directed();
    write_length(17'h1_0000);
    send(make(OP_POP, 3'd7, 3'd7, 32'd0, 16'd0));          // pop below bottom
    send(make(OP_PSH, 3'd0, 3'd0, 32'h8000_0000, 16'd0));  // back to -1 -> underflow
    send(make(OP_PSH, 3'd0, 3'd0, 32'h8000_0000, 16'd0));
    send(make(OP_PSH, 3'd0, 3'd0, 32'hFFFF_FFFF, 16'd0));
    send(make(OP_DIV, 3'd0, 3'd0, 32'd0, 16'd0));          // most negative / -1
    send(make(OP_PSH, 3'd0, 3'd0, 32'd0, 16'd0));
    send(make(OP_DIV, 3'd0, 3'd0, 32'd0, 16'd0));          // divide by zero
    send(make(OP_PSH, 3'd0, 3'd0, 32'h7FFF_FFFF, 16'hFFFF));
    send(make(OP_PSH, 3'd0, 3'd0, 32'd7, 16'd0));
    send(make(OP_MUL, 3'd0, 3'd0, 32'd0, 16'd0));
    send(make(OP_PSH, 3'd0, 3'd0, 32'hFFFF_FFF9, 16'd0));
    send(make(OP_SUB, 3'd0, 3'd0, 32'd0, 16'd0));
    send(make(OP_PSH, 3'd0, 3'd0, 32'd3, 16'd0));
    send(make(OP_ADD, 3'd0, 3'd0, 32'd0, 16'd0));
    send(make(OP_LOG, 3'd2, 3'd0, 32'd0, 16'd0));
    send(make(OP_MOV, 3'd2, 3'd5, 32'd0, 16'd0));
    send(make(OP_SET, 3'd4, 3'd0, 32'h5555_AAAA, 16'd0));
    send(make(OP_IF, 3'd4, 3'd0, 32'h5555_AAAA, 16'd40));  // taken
    send(make(OP_IFN, 3'd4, 3'd0, 32'h5555_AAAA, 16'd0));  // not taken
    send(make(OP_STR, 3'd3, 3'd0, 32'd0, 16'd0));
    send(make(OP_RTS, 3'd5, 3'd0, 32'd0, 16'd0));
    send(make(OP_NOP, 3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF));
    send(make(OP_JMP, 3'd0, 3'd0, 32'd0, 16'hFFFF));       // last word
    send(make(OP_LOG, 3'd6, 3'd0, 32'd0, 16'd0));          // runs, reaches the end
    send(make(OP_LOG, 3'd6, 3'd0, 32'd0, 16'd0));          // ignored
    drain();
  endtask

  // Overflow: push past the top of the stack, then set the pointer back in range and exit.
  task automatic test_overflow();
    write_length(17'h1_FFFF);
    send(make(OP_JMP, 3'd0, 3'd0, 32'd0, 16'd0));
    repeat (STACK_DEPTH + 2) send(make(OP_PSH, 3'd0, 3'd0, $urandom(), 16'd0));
    send(make(OP_STR, 3'd3, 3'd0, 32'd0, 16'd0));
    send(make(OP_ADD, 3'd0, 3'd0, 32'd0, 16'd0));
    send(make(OP_SET, 3'd7, 3'd0, 32'd3, 16'd0));          // pointer back in range
    send(make(OP_EXT, 3'd0, 3'd0, 32'd0, 16'd0));
    send(make(OP_PSH, 3'd0, 3'd0, 32'd1, 16'd0));          // ignored after exit
    drain();
  endtask

  // Random instructions; keep the pointer on written entries.
  function automatic in_t random_ins();
    in_t i;
    logic [31:0] sp;
    int depth;
    sp = vm_regs[REG_COUNT-1];
    depth = sp[31] ? 0 : ((sp >= STACK_DEPTH) ? STACK_DEPTH : sp + 1);
    i.reg_a = $urandom_range(0, 7);
    i.reg_b = $urandom_range(0, 5);            // keep the pointers mostly intact
    i.imm = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) - 1 : $urandom();
    i.target = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 200));
    case ($urandom_range(0, 13))
      0, 1: i.mode = (depth < STACK_DEPTH - 2) ? OP_PSH : OP_POP;
      2: i.mode = (depth > 0) ? OP_POP : OP_PSH;
      3, 4: i.mode = (depth >= 2) ? 4'($urandom_range(OP_ADD, OP_DIV)) : OP_PSH;
      5: i.mode = OP_LOG;
      6: i.mode = OP_MOV;
      7: i.mode = OP_SET;
      8: i.mode = $urandom_range(0, 1) ? OP_IF : OP_IFN;
      9: i.mode = OP_JMP;
      10: i.mode = (depth > 0) ? OP_STR : OP_PSH;
      11: i.mode = (depth < STACK_DEPTH - 2) ? OP_RTS : OP_POP;
      12: i.mode = OP_NOP;
      default: i.mode = OP_LOG;
    endcase
    if (i.mode == OP_MOV && i.reg_b == 3'd5) i.reg_b = 3'd4;
    if ((i.mode == OP_SET || i.mode == OP_STR) && i.reg_a >= 3'd6) i.reg_a = 3'd3;
    if (i.mode == OP_DIV && $urandom_range(0, 9) == 0) i.mode = OP_SUB;
    // Compare against the live register so both branches are taken.
    if ((i.mode == OP_IF || i.mode == OP_IFN) && $urandom_range(0, 1))
      i.imm = vm_regs[i.reg_a];
    return i;
  endfunction

  task automatic test_random(input int count, input logic [16:0] len);
    restart(len);
    for (int n = 0; n < count; n++) begin
      if (vm_halted()) restart(len);
      else send(random_ins());
    end
    drain();
  endtask

  // Back pressure: hold the result side so the queue fills and stalls input.
  task automatic test_backpressure();
    restart(17'd60000);
    fork
      begin
        hold_outputs = 1'b1;
        repeat (300) @(posedge clk);
        hold_outputs = 1'b0;
      end
      repeat (40) send(make(OP_PSH, 3'd0, 3'd0, $urandom(), 16'd0));
    join
    repeat (40) send(make(OP_POP, 3'd0, 3'd0, 32'd0, 16'd0));
    drain();
  endtask

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    vm_regs = '{default: 32'd0};
    vm_regs[REG_COUNT-1] = 32'hFFFF_FFFF;
    vm_stack = '{default: 32'd0};
    vm_running = 1'b1;
    vm_prog_len = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_halted_after_reset();
    test_directed();
    test_backpressure();
    test_random(450, 17'd150);
    test_random(450, 17'd201);
    test_random(300, 17'd1);
    idle_enable = 1'b0;
    test_random(250, 17'h1_0000);
    // Exit is sticky, so run it last.
    test_overflow();
    $display("ran %0d instructions, %0d results, %0d logs, %0d stack or divide errors",
             sent_count, result_count, log_count, error_count);
    $display("covered all opcodes, halting, wrap of the stack pointer and stalls");
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
